// File: rtl/opc_pkg.sv
package opc_pkg;

    // measurement and speed window lengths
    localparam int MEAS_LEN      = 256;   // power of two: the average is a shift
    localparam int MEAS_CNT_W    = $clog2(MEAS_LEN + 1);
    localparam int SPEED_WINDOW  = 40;
    localparam int WINDOW_W      = 6;

    // supply code: ((sum/4) * SUPPLY_SCALE >> 16) - SUPPLY_OFFSET
    localparam int SUPPLY_SCALE  = 1000;
    localparam int SUPPLY_OFFSET = 450;
    localparam int VDD_BASE      = 140;
    localparam int VDD_FLAG_LVL  = 300;
    localparam int VDD_MOD       = 100;

    // good measurement: min > GOOD_MIN_LVL and max*10/min > 20,
    // i.e. max*10 >= 21*min
    localparam int GOOD_MIN_LVL  = 40;
    localparam int RATIO_MUL     = 10;
    localparam int RATIO_LIMIT   = 21;

    localparam int FAST_HOLD     = 255;
    localparam int MEAS_FAST     = 10;
    localparam int INTERVAL_MEAS = 2;
    localparam int INTERVAL_FAST = 10;
    localparam int INTERVAL_SLOW = 15;

    localparam logic [7:0] SAT_VALUE = 8'hFF;

    // configuration register indexes
    localparam logic [1:0] REG_CALIBRATED = 2'd0;
    localparam logic [1:0] REG_LOW_REF    = 2'd1;
    localparam logic [1:0] REG_HIGH_REF   = 2'd2;
    localparam logic [1:0] REG_VDD_REF    = 2'd3;

    // measurement modes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_MEAS  = 2'd1;
    localparam logic [1:0] MODE_STORE = 2'd2;

    localparam int DIV_W      = 16;
    localparam int DIV_STEP_W = $clog2(DIV_W + 1);

    typedef struct packed {
        logic                  start;
        logic [DIV_W-1:0]      rem_init;   // must be below divisor
        logic [DIV_W-1:0]      bits;       // dividend bits, MSB first
        logic [DIV_W-1:0]      divisor;
        logic [DIV_STEP_W-1:0] steps;
    } div_cmd_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] quo;             // quotient in the low 'steps' bits
    } div_rsp_t;

endpackage

// File: rtl/opc_div.sv
module opc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  opc_pkg::div_cmd_t cmd,
    output opc_pkg::div_rsp_t rsp
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [opc_pkg::DIV_STEP_W-1:0] cnt_reg;
    logic [opc_pkg::DIV_W-1:0]      rem_reg;
    logic [opc_pkg::DIV_W-1:0]      bits_reg;
    logic [opc_pkg::DIV_W-1:0]      dvs_reg;

    logic [opc_pkg::DIV_W:0]        trial;
    logic                           ge;
    logic [opc_pkg::DIV_W:0]        diff;

    // one restoring step per cycle
    assign trial = {rem_reg, bits_reg[opc_pkg::DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            bits_reg <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.steps;
                rem_reg  <= cmd.rem_init;
                bits_reg <= cmd.bits;
                dvs_reg  <= cmd.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? diff[opc_pkg::DIV_W-1:0] : trial[opc_pkg::DIV_W-1:0];
                bits_reg <= {bits_reg[opc_pkg::DIV_W-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == opc_pkg::DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;
    assign rsp.quo  = bits_reg;

endmodule

// File: rtl/optical_pulse_counter_autocal.sv
// Optical pulse counter with supply-compensated hysteresis thresholds and
// self-calibration. One transaction on the input channel is one sampling tick
// and yields exactly one result transaction. Ticks are processed one at a
// time by a small sequencer around a shared restoring divider (one quotient
// bit per cycle). With the calibrated flag at 0 a tick skips detection and
// goes straight to the output; a calibrated tick goes through detection and
// measurement first; every fourth calibrated tick also recomputes the supply
// code and rescales both thresholds through 8-step divisions; the last tick of
// a calibration measurement also computes the supply-code modulo through the
// same divider. The input is stalled while a tick is in progress; a finished
// result sits in an output register, so the next tick can be taken while the
// previous result is still stalled. Configuration writes load the calibrated
// flag or the matching stored threshold or supply reference immediately.
module optical_pulse_counter_autocal (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sample_a,
    input  logic [15:0] sample_b,
    input  logic [15:0] sample_c,
    input  logic [15:0] vdd_sample,
    input  logic [1:0]  start_mode,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        pulse_event,
    output logic [31:0] pulse_total,
    output logic [7:0]  speed_value,
    output logic [3:0]  next_interval,
    output logic        report_valid,
    output logic [7:0]  rep_min,
    output logic [7:0]  rep_max,
    output logic [7:0]  rep_avg,
    output logic [7:0]  rep_low,
    output logic [7:0]  rep_high,
    output logic [7:0]  rep_vdd_byte,
    output logic [1:0]  rep_good
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DET   = 4'd1;
    localparam logic [3:0] ST_SCODE = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_MEAS  = 4'd5;
    localparam logic [3:0] ST_REP   = 4'd6;
    localparam logic [3:0] ST_MOD   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    // sequencer and tick scratch
    logic [3:0]  state_reg, state_next;
    logic        sel_reg, sel_next;
    logic [7:0]  med_reg, med_next;
    logic [15:0] vdd_reg, vdd_next;
    logic        event_reg, event_next;
    logic [3:0]  interval_reg, interval_next;
    logic        good_reg, good_next;

    // block state
    logic        calibrated_reg, calibrated_next;
    logic        level_high_reg, level_high_next;
    logic [31:0] pulse_count_reg, pulse_count_next;
    logic [7:0]  trans_reg, trans_next;
    logic [opc_pkg::WINDOW_W-1:0] window_reg, window_next;
    logic [7:0]  speed_reg, speed_next;
    logic [7:0]  fast_reg, fast_next;
    logic [17:0] supply_sum_reg, supply_sum_next;
    logic [1:0]  supply_ticks_reg, supply_ticks_next;
    logic [15:0] supply_code_reg, supply_code_next;
    logic [7:0]  thr_low_reg, thr_low_next;
    logic [7:0]  thr_high_reg, thr_high_next;
    logic [7:0]  stored_low_reg, stored_low_next;
    logic [7:0]  stored_high_reg, stored_high_next;
    logic [15:0] stored_vdd_reg, stored_vdd_next;
    logic [1:0]  meas_mode_reg, meas_mode_next;
    logic [opc_pkg::MEAS_CNT_W-1:0] meas_count_reg, meas_count_next;
    logic [7:0]  meas_min_reg, meas_min_next;
    logic [7:0]  meas_max_reg, meas_max_next;
    logic [15:0] meas_sum_reg, meas_sum_next;

    // report of the current tick
    logic        rv_reg, rv_next;
    logic [7:0]  rmin_reg, rmin_next;
    logic [7:0]  rmax_reg, rmax_next;
    logic [7:0]  ravg_reg, ravg_next;
    logic [7:0]  rlow_reg, rlow_next;
    logic [7:0]  rhigh_reg, rhigh_next;
    logic [7:0]  rvb_reg, rvb_next;
    logic [1:0]  rgood_reg, rgood_next;

    // output registers
    logic        out_valid_reg, out_valid_next;
    logic        o_event_reg, o_event_next;
    logic [31:0] o_total_reg, o_total_next;
    logic [7:0]  o_speed_reg, o_speed_next;
    logic [3:0]  o_interval_reg, o_interval_next;
    logic        o_rv_reg, o_rv_next;
    logic [7:0]  o_min_reg, o_min_next;
    logic [7:0]  o_max_reg, o_max_next;
    logic [7:0]  o_avg_reg, o_avg_next;
    logic [7:0]  o_low_reg, o_low_next;
    logic [7:0]  o_high_reg, o_high_next;
    logic [7:0]  o_vb_reg, o_vb_next;
    logic [1:0]  o_good_reg, o_good_next;

    opc_pkg::div_cmd_t div_cmd;
    opc_pkg::div_rsp_t div_rsp;

    logic        in_take;
    logic        out_take;
    logic [15:0] hi_ab, lo_ab, med16;
    logic [7:0]  rs_stored;
    logic [15:0] rs_off, rs_den;
    logic [23:0] rs_num;
    logic [25:0] scode_prod;
    logic [7:0]  span, span_t;
    logic [12:0] ratio_lhs, ratio_rhs;
    logic        meas_good;
    logic [opc_pkg::MEAS_CNT_W-1:0] meas_count_inc;
    logic [opc_pkg::WINDOW_W-1:0]   window_inc;
    logic        rep_ok;

    opc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    assign in_take  = in_valid && (state_reg == ST_IDLE);
    assign out_take = out_valid_reg && !out_stall;

    // median of three, top byte kept
    assign hi_ab = (sample_a > sample_b) ? sample_a : sample_b;
    assign lo_ab = (sample_a > sample_b) ? sample_b : sample_a;
    assign med16 = (sample_c >= hi_ab) ? hi_ab : ((sample_c <= lo_ab) ? lo_ab : sample_c);

    // threshold rescale operands
    assign rs_stored = sel_reg ? stored_high_reg : stored_low_reg;
    assign rs_off    = supply_code_reg - 16'(opc_pkg::VDD_BASE);
    assign rs_den    = stored_vdd_reg - 16'(opc_pkg::VDD_BASE);
    assign rs_num    = 24'(rs_stored) * 24'(rs_off);

    assign scode_prod = 26'(supply_sum_reg[17:2]) * 26'(opc_pkg::SUPPLY_SCALE);

    assign span      = (meas_max_reg >= meas_min_reg) ? (meas_max_reg - meas_min_reg) : 8'd0;
    assign span_t    = {3'b000, span[7:3]};
    assign ratio_lhs = 13'(meas_max_reg) * 13'(opc_pkg::RATIO_MUL);
    assign ratio_rhs = 13'(meas_min_reg) * 13'(opc_pkg::RATIO_LIMIT);
    assign meas_good = (meas_min_reg > 8'(opc_pkg::GOOD_MIN_LVL)) && (ratio_lhs >= ratio_rhs);

    assign meas_count_inc = meas_count_reg + 1'b1;
    assign window_inc     = window_reg + 1'b1;
    assign rep_ok         = good_reg || (meas_mode_reg == opc_pkg::MODE_STORE);

    always_comb
    begin
        state_next        = state_reg;
        sel_next          = sel_reg;
        med_next          = med_reg;
        vdd_next          = vdd_reg;
        event_next        = event_reg;
        interval_next     = interval_reg;
        good_next         = good_reg;
        calibrated_next   = calibrated_reg;
        level_high_next   = level_high_reg;
        pulse_count_next  = pulse_count_reg;
        trans_next        = trans_reg;
        window_next       = window_reg;
        speed_next        = speed_reg;
        fast_next         = fast_reg;
        supply_sum_next   = supply_sum_reg;
        supply_ticks_next = supply_ticks_reg;
        supply_code_next  = supply_code_reg;
        thr_low_next      = thr_low_reg;
        thr_high_next     = thr_high_reg;
        stored_low_next   = stored_low_reg;
        stored_high_next  = stored_high_reg;
        stored_vdd_next   = stored_vdd_reg;
        meas_mode_next    = meas_mode_reg;
        meas_count_next   = meas_count_reg;
        meas_min_next     = meas_min_reg;
        meas_max_next     = meas_max_reg;
        meas_sum_next     = meas_sum_reg;
        rv_next           = rv_reg;
        rmin_next         = rmin_reg;
        rmax_next         = rmax_reg;
        ravg_next         = ravg_reg;
        rlow_next         = rlow_reg;
        rhigh_next        = rhigh_reg;
        rvb_next          = rvb_reg;
        rgood_next        = rgood_reg;
        out_valid_next    = out_valid_reg;
        o_event_next      = o_event_reg;
        o_total_next      = o_total_reg;
        o_speed_next      = o_speed_reg;
        o_interval_next   = o_interval_reg;
        o_rv_next         = o_rv_reg;
        o_min_next        = o_min_reg;
        o_max_next        = o_max_reg;
        o_avg_next        = o_avg_reg;
        o_low_next        = o_low_reg;
        o_high_next       = o_high_reg;
        o_vb_next         = o_vb_reg;
        o_good_next       = o_good_reg;

        div_cmd          = '0;
        div_cmd.divisor  = rs_den;

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            case (cfg_index)
                opc_pkg::REG_CALIBRATED: calibrated_next  = cfg_data[0];
                opc_pkg::REG_LOW_REF:    stored_low_next  = cfg_data[7:0];
                opc_pkg::REG_HIGH_REF:   stored_high_next = cfg_data[7:0];
                opc_pkg::REG_VDD_REF:    stored_vdd_next  = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    med_next   = med16[15:8];
                    vdd_next   = vdd_sample;
                    event_next = 1'b0;
                    rv_next    = 1'b0;
                    rmin_next  = '0;
                    rmax_next  = '0;
                    ravg_next  = '0;
                    rlow_next  = '0;
                    rhigh_next = '0;
                    rvb_next   = '0;
                    rgood_next = '0;
                    if ((meas_mode_reg == opc_pkg::MODE_NONE) &&
                        ((start_mode == opc_pkg::MODE_MEAS) ||
                         (start_mode == opc_pkg::MODE_STORE)))
                    begin
                        meas_mode_next = start_mode;
                    end
                    if (!calibrated_reg)
                    begin
                        thr_low_next  = stored_low_reg;
                        thr_high_next = stored_high_reg;
                        interval_next = 4'(opc_pkg::INTERVAL_FAST);
                        state_next    = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_DET;
                    end
                end
            end

            ST_DET:
            begin
                if (med_reg > thr_high_reg)
                begin
                    if (!level_high_reg)
                    begin
                        pulse_count_next = pulse_count_reg + 1'b1;
                        level_high_next  = 1'b1;
                        trans_next       = trans_reg + 1'b1;
                        fast_next        = 8'(opc_pkg::FAST_HOLD);
                        event_next       = 1'b1;
                    end
                end
                else if (med_reg < thr_low_reg)
                begin
                    if (level_high_reg)
                    begin
                        level_high_next = 1'b0;
                        trans_next      = trans_reg + 1'b1;
                        fast_next       = 8'(opc_pkg::FAST_HOLD);
                    end
                end
                supply_sum_next   = supply_sum_reg + 18'(vdd_reg);
                supply_ticks_next = supply_ticks_reg + 1'b1;
                state_next        = (supply_ticks_reg == 2'd3) ? ST_SCODE : ST_MEAS;
            end

            ST_SCODE:
            begin
                supply_code_next = 16'(scode_prod[25:16]) - 16'(opc_pkg::SUPPLY_OFFSET);
                supply_sum_next  = '0;
                sel_next         = 1'b0;
                state_next       = ST_MUL;
            end

            ST_MUL:
            begin
                // quotient above 255 or zero divisor saturates, else 8 divider steps
                if ((rs_den == 16'd0) || (rs_num >= {rs_den, 8'h00}))
                begin
                    if (sel_reg)
                    begin
                        thr_high_next = opc_pkg::SAT_VALUE;
                        state_next    = ST_MEAS;
                    end
                    else
                    begin
                        thr_low_next = opc_pkg::SAT_VALUE;
                        sel_next     = 1'b1;
                    end
                end
                else
                begin
                    div_cmd.start    = 1'b1;
                    div_cmd.rem_init = rs_num[23:8];
                    div_cmd.bits     = {rs_num[7:0], 8'h00};
                    div_cmd.steps    = opc_pkg::DIV_STEP_W'(8);
                    state_next       = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (sel_reg)
                    begin
                        thr_high_next = div_rsp.quo[7:0];
                        state_next    = ST_MEAS;
                    end
                    else
                    begin
                        thr_low_next = div_rsp.quo[7:0];
                        sel_next     = 1'b1;
                        state_next   = ST_MUL;
                    end
                end
            end

            ST_MEAS:
            begin
                if (meas_mode_reg != opc_pkg::MODE_NONE)
                begin
                    if (med_reg < meas_min_reg)
                    begin
                        meas_min_next = med_reg;
                    end
                    if (med_reg > meas_max_reg)
                    begin
                        meas_max_next = med_reg;
                    end
                    meas_sum_next   = meas_sum_reg + 16'(med_reg);
                    meas_count_next = meas_count_inc;
                    if (meas_count_inc == opc_pkg::MEAS_CNT_W'(opc_pkg::MEAS_LEN))
                    begin
                        fast_next  = 8'(opc_pkg::MEAS_FAST);
                        state_next = ST_REP;
                    end
                    else
                    begin
                        fast_next     = 8'(opc_pkg::MEAS_FAST - 1);
                        interval_next = 4'(opc_pkg::INTERVAL_MEAS);
                        state_next    = ST_OUT;
                    end
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            ST_REP:
            begin
                rmin_next  = meas_min_reg;
                rmax_next  = meas_max_reg;
                ravg_next  = 8'(meas_sum_reg / opc_pkg::MEAS_LEN);
                rlow_next  = meas_min_reg + span_t;
                rhigh_next = meas_max_reg - span_t;
                good_next  = meas_good;
                // supply code modulo 100 through the shared divider
                div_cmd.start    = 1'b1;
                div_cmd.rem_init = '0;
                div_cmd.bits     = supply_code_reg;
                div_cmd.divisor  = 16'(opc_pkg::VDD_MOD);
                div_cmd.steps    = opc_pkg::DIV_STEP_W'(opc_pkg::DIV_W);
                state_next       = ST_MOD;
            end

            ST_MOD:
            begin
                if (div_rsp.done)
                begin
                    rv_next = rep_ok;
                    if (rep_ok)
                    begin
                        rvb_next = ((supply_code_reg > 16'(opc_pkg::VDD_FLAG_LVL)) ?
                                    8'h80 : 8'h00) + div_rsp.rem[7:0];
                    end
                    else
                    begin
                        rmin_next  = '0;
                        rmax_next  = '0;
                        ravg_next  = '0;
                        rlow_next  = '0;
                        rhigh_next = '0;
                        rvb_next   = '0;
                    end
                    if (good_reg)
                    begin
                        rgood_next = meas_mode_reg;
                        if (meas_mode_reg == opc_pkg::MODE_STORE)
                        begin
                            stored_low_next  = rlow_reg;
                            stored_high_next = rhigh_reg;
                            stored_vdd_next  = supply_code_reg;
                        end
                    end
                    meas_mode_next  = opc_pkg::MODE_NONE;
                    meas_count_next = '0;
                    meas_min_next   = 8'hFF;
                    meas_max_next   = '0;
                    meas_sum_next   = '0;
                    state_next      = ST_FIN;
                end
            end

            ST_FIN:
            begin
                window_next = window_inc;
                if (window_inc == opc_pkg::WINDOW_W'(opc_pkg::SPEED_WINDOW))
                begin
                    window_next = '0;
                    speed_next  = trans_reg;
                    trans_next  = '0;
                end
                if (fast_reg != 8'd0)
                begin
                    fast_next     = fast_reg - 1'b1;
                    interval_next = 4'(opc_pkg::INTERVAL_FAST);
                end
                else
                begin
                    interval_next = 4'(opc_pkg::INTERVAL_SLOW);
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next  = 1'b1;
                    o_event_next    = event_reg;
                    o_total_next    = pulse_count_reg;
                    o_speed_next    = speed_reg;
                    o_interval_next = interval_reg;
                    o_rv_next       = rv_reg;
                    o_min_next      = rmin_reg;
                    o_max_next      = rmax_reg;
                    o_avg_next      = ravg_reg;
                    o_low_next      = rlow_reg;
                    o_high_next     = rhigh_reg;
                    o_vb_next       = rvb_reg;
                    o_good_next     = rgood_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sel_reg          <= 1'b0;
            med_reg          <= '0;
            vdd_reg          <= '0;
            event_reg        <= 1'b0;
            interval_reg     <= '0;
            good_reg         <= 1'b0;
            calibrated_reg   <= 1'b0;
            level_high_reg   <= 1'b1;
            pulse_count_reg  <= '0;
            trans_reg        <= '0;
            window_reg       <= '0;
            speed_reg        <= '0;
            fast_reg         <= 8'(opc_pkg::FAST_HOLD);
            supply_sum_reg   <= '0;
            supply_ticks_reg <= '0;
            supply_code_reg  <= '0;
            thr_low_reg      <= '0;
            thr_high_reg     <= '0;
            stored_low_reg   <= '0;
            stored_high_reg  <= '0;
            stored_vdd_reg   <= '0;
            meas_mode_reg    <= opc_pkg::MODE_NONE;
            meas_count_reg   <= '0;
            meas_min_reg     <= 8'hFF;
            meas_max_reg     <= '0;
            meas_sum_reg     <= '0;
            rv_reg           <= 1'b0;
            rmin_reg         <= '0;
            rmax_reg         <= '0;
            ravg_reg         <= '0;
            rlow_reg         <= '0;
            rhigh_reg        <= '0;
            rvb_reg          <= '0;
            rgood_reg        <= '0;
            out_valid_reg    <= 1'b0;
            o_event_reg      <= 1'b0;
            o_total_reg      <= '0;
            o_speed_reg      <= '0;
            o_interval_reg   <= '0;
            o_rv_reg         <= 1'b0;
            o_min_reg        <= '0;
            o_max_reg        <= '0;
            o_avg_reg        <= '0;
            o_low_reg        <= '0;
            o_high_reg       <= '0;
            o_vb_reg         <= '0;
            o_good_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            sel_reg          <= sel_next;
            med_reg          <= med_next;
            vdd_reg          <= vdd_next;
            event_reg        <= event_next;
            interval_reg     <= interval_next;
            good_reg         <= good_next;
            calibrated_reg   <= calibrated_next;
            level_high_reg   <= level_high_next;
            pulse_count_reg  <= pulse_count_next;
            trans_reg        <= trans_next;
            window_reg       <= window_next;
            speed_reg        <= speed_next;
            fast_reg         <= fast_next;
            supply_sum_reg   <= supply_sum_next;
            supply_ticks_reg <= supply_ticks_next;
            supply_code_reg  <= supply_code_next;
            thr_low_reg      <= thr_low_next;
            thr_high_reg     <= thr_high_next;
            stored_low_reg   <= stored_low_next;
            stored_high_reg  <= stored_high_next;
            stored_vdd_reg   <= stored_vdd_next;
            meas_mode_reg    <= meas_mode_next;
            meas_count_reg   <= meas_count_next;
            meas_min_reg     <= meas_min_next;
            meas_max_reg     <= meas_max_next;
            meas_sum_reg     <= meas_sum_next;
            rv_reg           <= rv_next;
            rmin_reg         <= rmin_next;
            rmax_reg         <= rmax_next;
            ravg_reg         <= ravg_next;
            rlow_reg         <= rlow_next;
            rhigh_reg        <= rhigh_next;
            rvb_reg          <= rvb_next;
            rgood_reg        <= rgood_next;
            out_valid_reg    <= out_valid_next;
            o_event_reg      <= o_event_next;
            o_total_reg      <= o_total_next;
            o_speed_reg      <= o_speed_next;
            o_interval_reg   <= o_interval_next;
            o_rv_reg         <= o_rv_next;
            o_min_reg        <= o_min_next;
            o_max_reg        <= o_max_next;
            o_avg_reg        <= o_avg_next;
            o_low_reg        <= o_low_next;
            o_high_reg       <= o_high_next;
            o_vb_reg         <= o_vb_next;
            o_good_reg       <= o_good_next;
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign pulse_event   = o_event_reg;
    assign pulse_total   = o_total_reg;
    assign speed_value   = o_speed_reg;
    assign next_interval = o_interval_reg;
    assign report_valid  = o_rv_reg;
    assign rep_min       = o_min_reg;
    assign rep_max       = o_max_reg;
    assign rep_avg       = o_avg_reg;
    assign rep_low       = o_low_reg;
    assign rep_high      = o_high_reg;
    assign rep_vdd_byte  = o_vb_reg;
    assign rep_good      = o_good_reg;

endmodule
